### hw/rtl/sphere_polygon_pushback_top_macros.svh
// Assertion helpers for the sphere pushback block.
// Both take a label, an antecedent, a consequent and a message, and are
// clocked on aclk with the synchronous reset disabling them.
`ifndef SPHERE_POLYGON_PUSHBACK_TOP_MACROS_SVH
`define SPHERE_POLYGON_PUSHBACK_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SPP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SPP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/spp_pkg.sv
package spp_pkg;

    localparam int MAX_HIT_POLYGONS_DEF = 64;

    localparam int POS_W    = 32;
    localparam int NORM_W   = 16;
    localparam int RAD_W    = 31;
    localparam int GAP_W    = 21;
    localparam int STEP_W   = 21;
    localparam int EPS_W    = 15;
    localparam int DIFF_W   = POS_W + 1;
    localparam int PROD_W   = NORM_W + DIFF_W;
    localparam int DOT_W    = PROD_W + 2;
    localparam int DRND_W   = DOT_W + 1 - 14;
    localparam int DIST_W   = 34;
    localparam int OVL_W    = DIST_W + 2;
    localparam int PP_W     = NORM_W + OVL_W;
    localparam int PRND_W   = PP_W + 1 - 14;
    localparam int ROUND_HALF = 8192;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_GAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_EPS    = 2'd2;

    localparam logic [GAP_W-1:0]  OVERLAP_GAP_RST = 21'd32768;
    localparam logic [STEP_W-1:0] STEP_HEIGHT_RST = 21'd65536;
    localparam logic [EPS_W-1:0]  WALL_EPS_RST    = 15'd2;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_POLY  = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
        logic signed [POS_W-1:0]  vert1_y;
        logic signed [POS_W-1:0]  vert2_y;
        logic [RAD_W-1:0]         radius;
        logic                     is_static;
        logic                     last;
    } in_beat_t;

    typedef struct packed {
        logic signed [POS_W-1:0] floor_push_x;
        logic signed [POS_W-1:0] floor_push_y;
        logic signed [POS_W-1:0] floor_push_z;
        logic signed [POS_W-1:0] wall_push_x;
        logic signed [POS_W-1:0] wall_push_y;
        logic signed [POS_W-1:0] wall_push_z;
        logic                    floor_hit;
        logic                    wall_hit;
        logic                    on_floor;
    } out_beat_t;

    typedef logic signed [NORM_W-1:0] norm_t;
    typedef norm_t [2:0]              norm_vec_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef diff_t [2:0]              diff_vec_t;
    typedef logic [DIST_W-1:0]        dist_t;

    // Control that travels with each beat down the distance pipeline.
    typedef struct packed {
        logic             is_start;
        logic             last;
        logic [RAD_W-1:0] radius;
    } tag_t;

    typedef struct packed {
        tag_t      tag;
        logic      take_floor;
        logic      take_wall;
        norm_vec_t normal;
    } item_t;

    // End-of-query snapshot handed to the push unit.
    typedef struct packed {
        logic             floor_hit;
        logic             wall_hit;
        logic [RAD_W-1:0] radius;
        dist_t            floor_dist;
        dist_t            wall_dist;
        norm_vec_t        floor_normal;
        norm_vec_t        wall_normal;
    } summary_t;

endpackage

### hw/rtl/spp_dist.sv
// Three-stage plane distance pipeline: per-axis products, dot sum, then
// magnitude with rounding and saturation to the distance width.
module spp_dist (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  spp_pkg::item_t    in_item,
    input  spp_pkg::diff_vec_t in_diff,
    output logic              out_valid,
    output spp_pkg::item_t    out_item,
    output spp_pkg::dist_t    out_dist
);

    logic                                 a_valid_reg;
    spp_pkg::item_t                       a_item_reg;
    logic signed [spp_pkg::PROD_W-1:0]    a_prod_reg [3];
    logic signed [spp_pkg::PROD_W-1:0]    a_prod_next [3];

    logic                                 b_valid_reg;
    spp_pkg::item_t                       b_item_reg;
    logic signed [spp_pkg::DOT_W-1:0]     b_dot_reg;
    logic signed [spp_pkg::DOT_W-1:0]     b_dot_next;

    logic                                 c_valid_reg;
    spp_pkg::item_t                       c_item_reg;
    spp_pkg::dist_t                       c_dist_reg;
    spp_pkg::dist_t                       c_dist_next;

    logic [spp_pkg::DOT_W-1:0]            mag;
    logic [spp_pkg::DOT_W:0]              mag_rnd;
    logic [spp_pkg::DRND_W-1:0]           rnd;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_prod_next[i] = spp_pkg::PROD_W'(in_item.normal[i])
                           * spp_pkg::PROD_W'(in_diff[i]);
        end
    end

    always_comb begin
        b_dot_next = spp_pkg::DOT_W'(a_prod_reg[0]) + spp_pkg::DOT_W'(a_prod_reg[1])
                   + spp_pkg::DOT_W'(a_prod_reg[2]);
    end

    always_comb begin
        mag     = b_dot_reg[spp_pkg::DOT_W-1] ? -b_dot_reg : b_dot_reg;
        mag_rnd = {1'b0, mag} + (spp_pkg::DOT_W+1)'(spp_pkg::ROUND_HALF);
        rnd     = mag_rnd[spp_pkg::DOT_W:14];
        if (|rnd[spp_pkg::DRND_W-1:spp_pkg::DIST_W]) begin
            c_dist_next = '1;
        end else begin
            c_dist_next = rnd[spp_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_item_reg <= in_item;
            a_prod_reg <= a_prod_next;
            b_item_reg <= a_item_reg;
            b_dot_reg  <= b_dot_next;
            c_item_reg <= b_item_reg;
            c_dist_reg <= c_dist_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_item  = c_item_reg;
    assign out_dist  = c_dist_reg;

endmodule

### hw/rtl/spp_push.sv
// Push vector unit: overlap, then normal times overlap, then rounding and
// saturation of the six components into the result beat.
module spp_push (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  spp_pkg::summary_t             in_sum,
    input  logic [spp_pkg::GAP_W-1:0]     gap,
    output logic                          out_valid,
    output spp_pkg::out_beat_t            out_beat
);

    logic                               o_valid_reg;
    logic                               o_fhit_reg;
    logic                               o_whit_reg;
    logic signed [spp_pkg::OVL_W-1:0]   o_fovl_reg;
    logic signed [spp_pkg::OVL_W-1:0]   o_wovl_reg;
    spp_pkg::norm_vec_t                 o_fn_reg;
    spp_pkg::norm_vec_t                 o_wn_reg;
    logic signed [spp_pkg::OVL_W-1:0]   o_fovl_next;
    logic signed [spp_pkg::OVL_W-1:0]   o_wovl_next;

    logic                               p_valid_reg;
    logic                               p_fhit_reg;
    logic                               p_whit_reg;
    logic signed [spp_pkg::PP_W-1:0]    p_prod_reg [6];
    logic signed [spp_pkg::PP_W-1:0]    p_prod_next [6];

    logic signed [spp_pkg::POS_W-1:0]   push [6];

    function automatic logic signed [spp_pkg::POS_W-1:0] round_sat(
        input logic signed [spp_pkg::PP_W-1:0] p
    );
        logic [spp_pkg::PP_W-1:0]   m;
        logic [spp_pkg::PP_W:0]     t;
        logic [spp_pkg::PRND_W-1:0] r;
        logic signed [spp_pkg::POS_W-1:0] res;
        m = p[spp_pkg::PP_W-1] ? -p : p;
        t = {1'b0, m} + (spp_pkg::PP_W+1)'(spp_pkg::ROUND_HALF);
        r = t[spp_pkg::PP_W:14];
        if (!p[spp_pkg::PP_W-1]) begin
            if (r > spp_pkg::PRND_W'(32'h7FFF_FFFF)) begin
                res = 32'sh7FFF_FFFF;
            end else begin
                res = r[spp_pkg::POS_W-1:0];
            end
        end else begin
            if (r >= spp_pkg::PRND_W'(32'h8000_0000)) begin
                res = 32'sh8000_0000;
            end else begin
                res = -r[spp_pkg::POS_W-1:0];
            end
        end
        return res;
    endfunction

    always_comb begin
        o_fovl_next = $signed({5'b0, in_sum.radius}) - $signed({2'b0, in_sum.floor_dist})
                    + $signed({15'b0, gap});
        o_wovl_next = $signed({5'b0, in_sum.radius}) - $signed({2'b0, in_sum.wall_dist})
                    + $signed({15'b0, gap});
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p_prod_next[i]     = spp_pkg::PP_W'(o_fn_reg[i]) * spp_pkg::PP_W'(o_fovl_reg);
            p_prod_next[i + 3] = spp_pkg::PP_W'(o_wn_reg[i]) * spp_pkg::PP_W'(o_wovl_reg);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            push[i]     = p_fhit_reg ? round_sat(p_prod_reg[i]) : '0;
            push[i + 3] = p_whit_reg ? round_sat(p_prod_reg[i + 3]) : '0;
        end
        // The normal array is ordered z, y, x (index 2 is x).
        out_beat.floor_push_x = push[2];
        out_beat.floor_push_y = push[1];
        out_beat.floor_push_z = push[0];
        out_beat.wall_push_x  = push[5];
        out_beat.wall_push_y  = push[4];
        out_beat.wall_push_z  = push[3];
        out_beat.floor_hit    = p_fhit_reg;
        out_beat.wall_hit     = p_whit_reg;
        out_beat.on_floor     = p_fhit_reg && (push[1] > 0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
        end else if (en) begin
            o_valid_reg <= in_valid;
            p_valid_reg <= o_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_fhit_reg <= in_sum.floor_hit;
            o_whit_reg <= in_sum.wall_hit;
            o_fovl_reg <= o_fovl_next;
            o_wovl_reg <= o_wovl_next;
            o_fn_reg   <= in_sum.floor_normal;
            o_wn_reg   <= in_sum.wall_normal;
            p_fhit_reg <= o_fhit_reg;
            p_whit_reg <= o_whit_reg;
            p_prod_reg <= p_prod_next;
        end
    end

    assign out_valid = p_valid_reg;

endmodule

### hw/rtl/sphere_polygon_pushback_top.sv
// Sphere against polygon pushback. A query opens with a start beat (sphere
// centre, radius, static flag) and continues with polygon beats; the beat
// flagged last produces one result beat holding the floor and wall push
// vectors, their hit flags and on_floor. The block takes one beat every
// clock cycle while s_ready is high; after its last beat is accepted, a
// result passes through the stages of the pipeline in order (input register,
// three distance stages, the running-minimum stage, then overlap, multiply
// and the output register). Input ready drops only while a finished result
// sits in the output register untaken and another result has reached the
// end of the pipeline behind it; beats that produce no result keep flowing
// in the meantime. Configuration writes are always accepted (cfg_ready is
// tied high) and should only be issued while no query is in flight. Each
// class keeps at most MAX_HIT_POLYGONS polygons; later ones of that class
// are ignored. After a result the counts are cleared but the sphere is kept.
`include "sphere_polygon_pushback_top_macros.svh"

module sphere_polygon_pushback_top #(
    parameter int MAX_HIT_POLYGONS = spp_pkg::MAX_HIT_POLYGONS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  spp_pkg::in_beat_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output spp_pkg::out_beat_t                m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [spp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CntW = $clog2(MAX_HIT_POLYGONS + 1);

    // Global advance enable for every pipeline stage.
    logic en;

    // Configuration registers.
    logic [spp_pkg::GAP_W-1:0]  gap_reg;
    logic [spp_pkg::STEP_W-1:0] step_reg;
    logic [spp_pkg::EPS_W-1:0]  eps_reg;

    // Stored sphere.
    logic signed [spp_pkg::POS_W-1:0] cx_reg;
    logic signed [spp_pkg::POS_W-1:0] cy_reg;
    logic signed [spp_pkg::POS_W-1:0] cz_reg;
    logic [spp_pkg::RAD_W-1:0]        radius_reg;
    logic                             static_reg;

    // Input stage.
    logic                       s1_valid_reg;
    spp_pkg::item_t             s1_item_reg;
    spp_pkg::diff_vec_t         s1_diff_reg;
    spp_pkg::item_t             s1_item_next;
    spp_pkg::diff_vec_t         s1_diff_next;
    logic                       is_start;
    logic [spp_pkg::NORM_W:0]   abs_ny;
    logic                       is_wall;
    logic signed [spp_pkg::DIFF_W-1:0] step_lim;
    logic                       rises;

    // Distance pipeline output.
    logic                       d_valid;
    spp_pkg::item_t             d_item;
    spp_pkg::dist_t             d_dist;

    // Running nearest polygon per class.
    logic [CntW-1:0]            floor_cnt_reg;
    logic [CntW-1:0]            wall_cnt_reg;
    logic [CntW-1:0]            floor_cnt_next;
    logic [CntW-1:0]            wall_cnt_next;
    spp_pkg::dist_t             floor_best_reg;
    spp_pkg::dist_t             wall_best_reg;
    spp_pkg::dist_t             floor_best_next;
    spp_pkg::dist_t             wall_best_next;
    spp_pkg::norm_vec_t         floor_n_reg;
    spp_pkg::norm_vec_t         wall_n_reg;
    spp_pkg::norm_vec_t         floor_n_next;
    spp_pkg::norm_vec_t         wall_n_next;

    // End-of-query snapshot.
    logic                       sum_valid_reg;
    spp_pkg::summary_t          sum_reg;
    spp_pkg::summary_t          sum_next;

    // Push unit and output register.
    logic                       push_valid;
    spp_pkg::out_beat_t         push_beat;
    logic                       m_valid_reg;
    spp_pkg::out_beat_t         m_data_reg;

    // The pipeline only stops when a new result would overwrite one that
    // the consumer has not taken yet.
    assign en        = !(m_valid_reg && !m_ready && push_valid);
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_reg  <= spp_pkg::OVERLAP_GAP_RST;
            step_reg <= spp_pkg::STEP_HEIGHT_RST;
            eps_reg  <= spp_pkg::WALL_EPS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                spp_pkg::CFG_OVERLAP_GAP: begin
                    gap_reg <= cfg_data[spp_pkg::GAP_W-1:0];
                end
                spp_pkg::CFG_STEP_HEIGHT: begin
                    step_reg <= cfg_data[spp_pkg::STEP_W-1:0];
                end
                spp_pkg::CFG_WALL_EPS: begin
                    eps_reg <= cfg_data[spp_pkg::EPS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input stage: offsets from vertex 0 to the centre, wall/floor class and
    // the step-height test all use the sphere as it stands when the beat is
    // accepted, so a polygon right behind a start beat sees the new sphere.
    always_comb begin
        is_start = (s_data.cmd == spp_pkg::CMD_START);
        abs_ny   = s_data.normal_y[spp_pkg::NORM_W-1]
                 ? -{s_data.normal_y[spp_pkg::NORM_W-1], s_data.normal_y}
                 : {s_data.normal_y[spp_pkg::NORM_W-1], s_data.normal_y};
        is_wall  = abs_ny < {2'b0, eps_reg};
        step_lim = spp_pkg::DIFF_W'(cy_reg) + $signed({12'b0, step_reg});
        rises    = (spp_pkg::DIFF_W'(s_data.pos_y) > step_lim)
                || (spp_pkg::DIFF_W'(s_data.vert1_y) > step_lim)
                || (spp_pkg::DIFF_W'(s_data.vert2_y) > step_lim);

        s1_diff_next[2] = spp_pkg::DIFF_W'(cx_reg) - spp_pkg::DIFF_W'(s_data.pos_x);
        s1_diff_next[1] = spp_pkg::DIFF_W'(cy_reg) - spp_pkg::DIFF_W'(s_data.pos_y);
        s1_diff_next[0] = spp_pkg::DIFF_W'(cz_reg) - spp_pkg::DIFF_W'(s_data.pos_z);

        s1_item_next.tag.is_start = is_start;
        s1_item_next.tag.last     = s_data.last;
        s1_item_next.tag.radius   = is_start ? s_data.radius : radius_reg;
        s1_item_next.take_floor   = !is_start && !static_reg && !is_wall;
        s1_item_next.take_wall    = !is_start && !static_reg && is_wall && rises;
        s1_item_next.normal[2]    = s_data.normal_x;
        s1_item_next.normal[1]    = s_data.normal_y;
        s1_item_next.normal[0]    = s_data.normal_z;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
            radius_reg <= '0;
            static_reg <= 1'b0;
        end else if (s_valid && en && is_start) begin
            cx_reg     <= s_data.pos_x;
            cy_reg     <= s_data.pos_y;
            cz_reg     <= s_data.pos_z;
            radius_reg <= s_data.radius;
            static_reg <= s_data.is_static;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_item_reg <= s1_item_next;
            s1_diff_reg <= s1_diff_next;
        end
    end

    spp_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .in_item   (s1_item_reg),
        .in_diff   (s1_diff_reg),
        .out_valid (d_valid),
        .out_item  (d_item),
        .out_dist  (d_dist)
    );

    // Running minimum per class. A strictly smaller distance replaces the
    // best, so on a tie the earlier polygon stays. The last beat's own
    // polygon is folded in before the snapshot is taken.
    always_comb begin
        floor_cnt_next  = floor_cnt_reg;
        wall_cnt_next   = wall_cnt_reg;
        floor_best_next = floor_best_reg;
        wall_best_next  = wall_best_reg;
        floor_n_next    = floor_n_reg;
        wall_n_next     = wall_n_reg;
        if (d_valid) begin
            if (d_item.tag.is_start) begin
                floor_cnt_next = '0;
                wall_cnt_next  = '0;
            end else begin
                if (d_item.take_floor && floor_cnt_reg < CntW'(MAX_HIT_POLYGONS)) begin
                    if (floor_cnt_reg == '0 || d_dist < floor_best_reg) begin
                        floor_best_next = d_dist;
                        floor_n_next    = d_item.normal;
                    end
                    floor_cnt_next = floor_cnt_reg + CntW'(1);
                end
                if (d_item.take_wall && wall_cnt_reg < CntW'(MAX_HIT_POLYGONS)) begin
                    if (wall_cnt_reg == '0 || d_dist < wall_best_reg) begin
                        wall_best_next = d_dist;
                        wall_n_next    = d_item.normal;
                    end
                    wall_cnt_next = wall_cnt_reg + CntW'(1);
                end
            end
        end

        sum_next.floor_hit    = (floor_cnt_next != '0);
        sum_next.wall_hit     = (wall_cnt_next != '0);
        sum_next.radius       = d_item.tag.radius;
        sum_next.floor_dist   = floor_best_next;
        sum_next.wall_dist    = wall_best_next;
        sum_next.floor_normal = floor_n_next;
        sum_next.wall_normal  = wall_n_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_cnt_reg <= '0;
            wall_cnt_reg  <= '0;
            sum_valid_reg <= 1'b0;
        end else if (en) begin
            if (d_valid && d_item.tag.last) begin
                floor_cnt_reg <= '0;
                wall_cnt_reg  <= '0;
            end else begin
                floor_cnt_reg <= floor_cnt_next;
                wall_cnt_reg  <= wall_cnt_next;
            end
            sum_valid_reg <= d_valid && d_item.tag.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            floor_best_reg <= floor_best_next;
            wall_best_reg  <= wall_best_next;
            floor_n_reg    <= floor_n_next;
            wall_n_reg     <= wall_n_next;
            sum_reg        <= sum_next;
        end
    end

    spp_push u_push (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sum_valid_reg),
        .in_sum    (sum_reg),
        .gap       (gap_reg),
        .out_valid (push_valid),
        .out_beat  (push_beat)
    );

    // Output register: loads whenever a result arrives and the slot is free
    // or being emptied this cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en && push_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && push_valid) begin
            m_data_reg <= push_beat;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SPP_ASSERT_IMP(a_floor_cnt_max, 1'b1, floor_cnt_reg <= CntW'(MAX_HIT_POLYGONS), "floor count above limit")
    `SPP_ASSERT_IMP(a_on_floor_hit, m_valid_reg && m_data_reg.on_floor, m_data_reg.floor_hit && (m_data_reg.floor_push_y > 0), "on_floor without upward floor push")
    `SPP_ASSERT_IMP(a_wall_zero, m_valid_reg && !m_data_reg.wall_hit, (m_data_reg.wall_push_x == 0) && (m_data_reg.wall_push_y == 0) && (m_data_reg.wall_push_z == 0), "wall push without wall hit")
    `SPP_ASSERT_NXT(a_sphere_load, s_valid && s_ready && (s_data.cmd == spp_pkg::CMD_START), radius_reg == $past(s_data.radius), "sphere radius not captured on start beat")

endmodule
